/* rtl/tawb_pkg.sv */
// Shared types, constants and event codes for the tar archive block walker.
package tawb_pkg;

  // Block geometry.
  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned OFF_BITS    = $clog2(BLOCK_BYTES);

  // Default width of the running block counter.
  localparam int unsigned BLOCK_COUNT_BITS_DEF = 32;

  // Field widths of the result item and derived counter widths.
  localparam int unsigned SIZE_BITS  = 33;
  localparam int unsigned BLKNO_BITS = 32;
  localparam int unsigned CNT_BITS   = SIZE_BITS + 1 - OFF_BITS;
  localparam int unsigned LEFT_BITS  = 24;

  // Header field positions within a block.
  localparam logic [OFF_BITS-1:0] SIZE_FIRST  = OFF_BITS'(124);
  localparam logic [OFF_BITS-1:0] SIZE_LAST   = OFF_BITS'(135);
  localparam logic [OFF_BITS-1:0] TYPE_OFF    = OFF_BITS'(156);
  localparam logic [OFF_BITS-1:0] MAGIC_FIRST = OFF_BITS'(257);
  localparam logic [OFF_BITS-1:0] MAGIC_LAST  = OFF_BITS'(262);
  localparam logic [OFF_BITS-1:0] OFF_LAST    = OFF_BITS'(BLOCK_BYTES - 1);

  // Largest size value; the octal parse saturates here.
  localparam logic [SIZE_BITS-1:0] SIZE_MAX = {SIZE_BITS{1'b1}};

  // Accepted typeflag for a regular file.
  localparam logic [7:0] TYPE_REGULAR = 8'h30;

  // Magic string "ustar " as it appears in the header.
  localparam logic [7:0] MAGIC [6] = '{8'h75, 8'h73, 8'h74, 8'h61, 8'h72, 8'h20};

  // Depth of the result queue.
  localparam int unsigned OUTQ_DEPTH = 3;
  localparam int unsigned OUTQ_PTR_BITS = $clog2(OUTQ_DEPTH);
  localparam int unsigned OUTQ_CNT_BITS = $clog2(OUTQ_DEPTH + 1);

  // Event codes carried in event_res.
  typedef enum logic [2:0] {
    EV_ENTRY     = 3'd0,
    EV_TWO_ZERO  = 3'd1,
    EV_LONE_ZERO = 3'd2,
    EV_CLEAN_END = 3'd3,
    EV_UNEXP_END = 3'd4,
    EV_BAD_HDR   = 3'd5,
    EV_NOT_TAR   = 3'd6,
    EV_BAD_TYPE  = 3'd7
  } event_t;

  // Walker phase, one-hot.
  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_CONTENT = 3'b010,
    PH_DONE    = 3'b100
  } phase_t;

  // Size field parse stage, one-hot.
  typedef enum logic [2:0] {
    SZ_SKIP   = 3'b001,
    SZ_DIGITS = 3'b010,
    SZ_DONE   = 3'b100
  } size_stage_t;

  // Input item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [2:0]            event_res;
    logic [SIZE_BITS-1:0]  file_size;
    logic [BLKNO_BITS-1:0] block_number;
    logic [7:0]            type_flag;
  } out_item_t;

endpackage

/* rtl/tar_archive_block_walker.sv */
// Top level of the tar archive block walker: input stage, parser and result queue.
//
//  channel | direction | payload            | handshake
//  --------+-----------+--------------------+---------------------
//  in_     | input     | in_item_t          | in_valid / in_stall
//  out_    | output    | out_item_t         | out_valid / out_stall
//
// One archive byte is taken per cycle while in_stall is low; each byte is held in the
// input register and its event, if any, enters the result queue the cycle after.
// Reset (rst_n low, synchronous) returns the walker to the header phase of block 0
// and empties the result queue.
// in_stall rises only when the three-entry result queue cannot take another
// event; with out_stall held low from reset the input never stalls.
module tar_archive_block_walker #(
  parameter int unsigned BLOCK_COUNT_BITS = tawb_pkg::BLOCK_COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tawb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tawb_pkg::out_item_t out_data
);
  import tawb_pkg::*;

  logic                     in_fire;
  logic                     item_pending_r;
  logic                     res_valid;
  out_item_t                res_item;
  logic [OUTQ_CNT_BITS-1:0] q_count;

  // Hold off input when the queue could overflow with the byte in flight.
  assign in_stall = (q_count == OUTQ_CNT_BITS'(OUTQ_DEPTH)) ||
                    ((q_count == OUTQ_CNT_BITS'(OUTQ_DEPTH - 1)) && item_pending_r);
  assign in_fire  = in_valid & ~in_stall;

  // Tracks the byte sitting in the parser's input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_pending_r <= 1'b0;
    end else begin
      item_pending_r <= in_fire;
    end
  end

  tawb_core #(
    .BLOCK_COUNT_BITS(BLOCK_COUNT_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_item  (in_data),
    .res_valid(res_valid),
    .res_item (res_item)
  );

  tawb_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_valid),
    .push_item(res_item),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .count    (q_count)
  );

endmodule

/* rtl/tawb_core.sv */
// Byte-wise header parser and block sequencer of the tar archive block walker.
module tawb_core #(
  parameter int unsigned BLOCK_COUNT_BITS = tawb_pkg::BLOCK_COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  tawb_pkg::in_item_t  in_item,
  output logic                res_valid,
  output tawb_pkg::out_item_t res_item
);
  import tawb_pkg::*;

  logic                        item_valid_r;
  in_item_t                    item_r;

  phase_t                      phase_r, phase_nxt;
  logic [OFF_BITS-1:0]         off_r, off_nxt;
  logic                        baz_r, baz_nxt;
  logic                        name_empty_r, name_empty_nxt;
  logic                        magic_r, magic_nxt;
  logic [7:0]                  type_r, type_nxt;
  logic [SIZE_BITS-1:0]        acc_r, acc_nxt;
  size_stage_t                 stage_r, stage_nxt;
  logic [LEFT_BITS-1:0]        left_r, left_nxt;
  logic [1:0]                  zc_r, zc_nxt;
  logic [BLOCK_COUNT_BITS-1:0] bp_r, bp_nxt;

  logic [7:0]                  b;
  logic                        last;
  logic [OFF_BITS-1:0]         off_inc;
  logic [BLOCK_COUNT_BITS-1:0] bp_inc;
  logic                        first;
  logic                        baz_cur;
  logic                        magic_cur;
  logic [7:0]                  type_cur;
  logic [SIZE_BITS-1:0]        acc_cur;
  size_stage_t                 stage_cur;
  logic                        is_ws;
  logic                        is_dig;
  logic [SIZE_BITS+2:0]        acc_shift;
  logic [SIZE_BITS-1:0]        acc_parsed;
  size_stage_t                 stage_parsed;
  logic [OFF_BITS-1:0]         magic_idx;
  logic [SIZE_BITS:0]          size_round;
  logic [CNT_BITS-1:0]         blk_cnt;

  // Input register: one byte per transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= in_fire;
    end
    if (in_fire) begin
      item_r <= in_item;
    end
  end

  // Common per-byte terms.
  assign b       = item_r.data_byte;
  assign last    = (off_r == OFF_LAST);
  assign off_inc = last ? '0 : off_r + OFF_BITS'(1);
  assign bp_inc  = bp_r + BLOCK_COUNT_BITS'(1);
  assign first   = (off_r == '0);

  // Header fields restart at the first byte of every header block.
  assign baz_cur   = first ? 1'b1 : baz_r;
  assign magic_cur = first ? 1'b1 : magic_r;
  assign type_cur  = first ? 8'h00 : type_r;
  assign acc_cur   = first ? '0 : acc_r;
  assign stage_cur = first ? SZ_SKIP : stage_r;

  // Octal size parse: skip leading white space, then accumulate digits.
  assign is_ws  = (b == 8'h20) || (b == 8'h09) || (b == 8'h0a) ||
                  (b == 8'h0b) || (b == 8'h0c) || (b == 8'h0d);
  assign is_dig = (b >= 8'h30) && (b <= 8'h37);
  assign acc_shift = {acc_cur, 3'b000} + {{SIZE_BITS{1'b0}}, b[2:0]};

  always_comb begin
    acc_parsed   = acc_cur;
    stage_parsed = stage_cur;
    if ((stage_cur == SZ_SKIP) && is_ws) begin
      stage_parsed = SZ_SKIP;
    end else if ((stage_cur != SZ_DONE) && is_dig) begin
      acc_parsed   = (acc_shift > {3'b000, SIZE_MAX}) ? SIZE_MAX : acc_shift[SIZE_BITS-1:0];
      stage_parsed = SZ_DIGITS;
    end else begin
      stage_parsed = SZ_DONE;
    end
  end

  assign magic_idx = off_r - MAGIC_FIRST;

  // Content blocks covered by the size, rounded up.
  assign size_round = {1'b0, acc_r} + (SIZE_BITS + 1)'(BLOCK_BYTES - 1);
  assign blk_cnt    = size_round[SIZE_BITS:OFF_BITS];

  // Next state and result of the byte in the input register.
  always_comb begin
    phase_nxt      = phase_r;
    off_nxt        = off_r;
    baz_nxt        = baz_r;
    name_empty_nxt = name_empty_r;
    magic_nxt      = magic_r;
    type_nxt       = type_r;
    acc_nxt        = acc_r;
    stage_nxt      = stage_r;
    left_nxt       = left_r;
    zc_nxt         = zc_r;
    bp_nxt         = bp_r;
    res_valid      = 1'b0;
    res_item       = '0;

    if (item_valid_r) begin
      case (phase_r)
        PH_HEADER: begin
          if (item_r.stream_end) begin
            // Stream ends between or inside header blocks.
            phase_nxt = PH_DONE;
            res_valid = 1'b1;
            if (zc_r != 2'd0) begin
              res_item.event_res    = EV_LONE_ZERO;
              res_item.block_number = BLKNO_BITS'(bp_inc);
            end else if (first) begin
              res_item.event_res = EV_CLEAN_END;
            end else begin
              res_item.event_res = EV_UNEXP_END;
            end
          end else begin
            // Collect the header checks as the byte streams by.
            off_nxt   = off_inc;
            baz_nxt   = baz_cur & (b == 8'h00);
            magic_nxt = magic_cur;
            type_nxt  = type_cur;
            acc_nxt   = acc_cur;
            stage_nxt = stage_cur;
            if (first) begin
              name_empty_nxt = (b == 8'h00);
            end
            if ((off_r >= SIZE_FIRST) && (off_r <= SIZE_LAST)) begin
              acc_nxt   = acc_parsed;
              stage_nxt = stage_parsed;
            end
            if (off_r == TYPE_OFF) begin
              type_nxt = b;
            end
            if ((off_r >= MAGIC_FIRST) && (off_r <= MAGIC_LAST) &&
                (MAGIC[magic_idx[2:0]] != b)) begin
              magic_nxt = 1'b0;
            end

            // Decide at the last byte of the header block.
            if (last) begin
              if (name_empty_r) begin
                if (!baz_nxt) begin
                  phase_nxt          = PH_DONE;
                  res_valid          = 1'b1;
                  res_item.event_res = EV_BAD_HDR;
                end else begin
                  zc_nxt = zc_r + 2'd1;
                  if (zc_r != 2'd0) begin
                    phase_nxt          = PH_DONE;
                    res_valid          = 1'b1;
                    res_item.event_res = EV_TWO_ZERO;
                  end
                end
              end else if (zc_r != 2'd0) begin
                phase_nxt             = PH_DONE;
                res_valid             = 1'b1;
                res_item.event_res    = EV_LONE_ZERO;
                res_item.block_number = BLKNO_BITS'(bp_inc);
              end else if (!magic_r) begin
                phase_nxt          = PH_DONE;
                res_valid          = 1'b1;
                res_item.event_res = EV_NOT_TAR;
              end else if ((type_r != TYPE_REGULAR) && (type_r != 8'h00)) begin
                phase_nxt          = PH_DONE;
                res_valid          = 1'b1;
                res_item.event_res = EV_BAD_TYPE;
                res_item.type_flag = type_r;
              end else begin
                // Accepted entry: report it and skip its content blocks.
                res_valid             = 1'b1;
                res_item.event_res    = EV_ENTRY;
                res_item.file_size    = acc_r;
                res_item.block_number = BLKNO_BITS'(bp_r);
                res_item.type_flag    = type_r;
                bp_nxt                = bp_inc;
                if (blk_cnt != '0) begin
                  left_nxt  = LEFT_BITS'(blk_cnt - CNT_BITS'(1));
                  phase_nxt = PH_CONTENT;
                end
              end
            end
          end
        end
        PH_CONTENT: begin
          if (item_r.stream_end) begin
            phase_nxt          = PH_DONE;
            res_valid          = 1'b1;
            res_item.event_res = EV_UNEXP_END;
          end else begin
            // Count content blocks as they pass.
            off_nxt = off_inc;
            if (last) begin
              bp_nxt = bp_inc;
              if (left_r == '0) begin
                phase_nxt = PH_HEADER;
              end else begin
                left_nxt = left_r - LEFT_BITS'(1);
              end
            end
          end
        end
        PH_DONE: begin
          // Everything after a terminal event is dropped.
        end
        default: begin
          phase_nxt = PH_DONE;
        end
      endcase
    end
  end

  // Walker state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      off_r        <= '0;
      baz_r        <= 1'b1;
      name_empty_r <= 1'b0;
      magic_r      <= 1'b1;
      type_r       <= 8'h00;
      acc_r        <= '0;
      stage_r      <= SZ_SKIP;
      left_r       <= '0;
      zc_r         <= 2'd0;
      bp_r         <= '0;
    end else begin
      phase_r      <= phase_nxt;
      off_r        <= off_nxt;
      baz_r        <= baz_nxt;
      name_empty_r <= name_empty_nxt;
      magic_r      <= magic_nxt;
      type_r       <= type_nxt;
      acc_r        <= acc_nxt;
      stage_r      <= stage_nxt;
      left_r       <= left_nxt;
      zc_r         <= zc_nxt;
      bp_r         <= bp_nxt;
    end
  end

endmodule

/* rtl/tawb_outq.sv */
// Small result queue that decouples the parser from the output stall.
module tawb_outq (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  input  tawb_pkg::out_item_t                  push_item,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output tawb_pkg::out_item_t                  out_data,
  output logic [tawb_pkg::OUTQ_CNT_BITS-1:0]   count
);
  import tawb_pkg::*;

  out_item_t                q_mem [OUTQ_DEPTH];
  logic [OUTQ_PTR_BITS-1:0] head_r, head_nxt;
  logic [OUTQ_PTR_BITS-1:0] tail_r, tail_nxt;
  logic [OUTQ_CNT_BITS-1:0] count_r, count_nxt;
  logic                     pop;

  assign out_valid = (count_r != '0);
  assign out_data  = q_mem[head_r];
  assign count     = count_r;
  assign pop       = out_valid & ~out_stall;

  // Pointer and fill-count update with wrap at the queue depth.
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (pop) begin
      head_nxt = (head_r == OUTQ_PTR_BITS'(OUTQ_DEPTH - 1)) ? '0 : head_r + OUTQ_PTR_BITS'(1);
    end
    if (push) begin
      tail_nxt = (tail_r == OUTQ_PTR_BITS'(OUTQ_DEPTH - 1)) ? '0 : tail_r + OUTQ_PTR_BITS'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + OUTQ_CNT_BITS'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - OUTQ_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[tail_r] <= push_item;
    end
  end

endmodule

/* rtl/tawb_checker.sv */
// Port-level checks for the tar archive block walker and the bind that attaches them.
module tawb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input tawb_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input tawb_pkg::out_item_t out_data
);
  import tawb_pkg::*;

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or vanished");

  // Nothing follows the transfer of a terminal event.
  a_terminal_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && (out_data.event_res != EV_ENTRY) |=> !out_valid)
    else $error("result after a terminal event");

  // Only entry events carry a size.
  a_size_entry_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_res != EV_ENTRY) |-> (out_data.file_size == '0))
    else $error("size on a terminal event");

  // An unsupported-type event never names a regular-file typeflag.
  a_bad_type_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_res == EV_BAD_TYPE) |->
      (out_data.type_flag != TYPE_REGULAR) && (out_data.type_flag != 8'h00))
    else $error("unsupported-type event with a regular typeflag");

  // With no result waiting the input is never held off.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while the result queue is empty");

endmodule

bind tar_archive_block_walker tawb_checker u_tawb_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

/* tb/tb_tar_archive_block_walker.sv */
// Self-checking testbench for the tar archive block walker: byte stream in, header events out.
`timescale 1ns / 1ps

module tb_tar_archive_block_walker;
  import tawb_pkg::*;

  // Header layout and tar constants used by the generator and the predictor.
  localparam int BLK         = 512;
  localparam int OFS_SIZE    = 124;
  localparam int SIZE_LEN    = 12;
  localparam int OFS_TYPE    = 156;
  localparam int OFS_MAGIC   = 257;
  localparam int MAGIC_LEN   = 6;
  localparam int HOLD_CYCLES = 6000;
  localparam logic [47:0] USTAR_MAGIC  = 48'h75_73_74_61_72_20;
  localparam logic [7:0]  FLAG_REGULAR = 8'h30;

  // How a size field is spelled out.
  typedef enum int {FMT_PLAIN, FMT_EMPTY, FMT_BLANK, FMT_SIGNED, FMT_ANY} size_fmt_t;

  // How the archive stops.
  typedef enum int {
    END_TWO_ZERO, END_ZERO_THEN_HDR, END_ZERO_THEN_EOS, END_CLEAN, END_MID_HEADER,
    END_MID_CONTENT, END_EMPTY_NAME, END_BAD_MAGIC, END_BAD_TYPE
  } end_kind_t;

  // One queued input transfer, optionally held back until all expected events are out.
  typedef struct {
    in_item_t item;
    bit       drain_first;
  } pend_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  tar_archive_block_walker dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  pend_t     archive_bytes[$];
  out_item_t want_events[$];
  pend_t     next_byte;
  out_item_t want;
  bit        drain_next = 1'b0;
  bit        in_acc = 1'b0;
  int        n_acc = 0;
  int        n_items = 0;
  int        err_cnt = 0;
  int        hold_at = 32'h7fff_ffff;
  int        quiet_at = 32'h7fff_ffff;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  int        tx_gap = 0;
  int        rx_gap = 0;

  // Walker state as the predictor tracks it.
  phase_t      w_phase = PH_HEADER;
  logic [8:0]  w_off = '0;
  bit          w_all_zero = 1'b1;
  bit          w_name_empty = 1'b0;
  bit          w_magic_ok = 1'b1;
  logic [7:0]  w_type = '0;
  logic [32:0] w_size = '0;
  size_stage_t w_stage = SZ_SKIP;
  logic [23:0] w_left = '0;
  logic [1:0]  w_zeros = '0;
  logic [31:0] w_blocks = '0;

  // Advance the walker by one accepted byte and queue the event it raises, if any.
  task automatic walk_byte(input in_item_t it);
    logic [7:0]  b;
    logic [35:0] acc8;
    logic [33:0] rounded;
    logic [24:0] nblk;
    bit          last;
    bit          ws;
    bit          dig;
    bit          fire;
    out_item_t   ev;
    int          k;
    b    = it.data_byte;
    last = (w_off == 9'(BLK - 1));
    ws   = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    dig  = (b >= 8'h30 && b <= 8'h37);
    fire = 1'b0;
    ev   = '0;
    if (w_phase == PH_DONE) begin
      // Everything after a terminal event is dropped.
    end else if (it.stream_end) begin
      fire = 1'b1;
      if (w_phase == PH_CONTENT) begin
        ev.event_res = EV_UNEXP_END;
      end else if (w_zeros != 0) begin
        ev.event_res    = EV_LONE_ZERO;
        ev.block_number = w_blocks + 32'd1;
      end else if (w_off == 0) begin
        ev.event_res = EV_CLEAN_END;
      end else begin
        ev.event_res = EV_UNEXP_END;
      end
      w_phase = PH_DONE;
    end else if (w_phase == PH_CONTENT) begin
      // Content bytes only move the block counters.
      if (last) begin
        w_blocks = w_blocks + 32'd1;
        if (w_left == 0) w_phase = PH_HEADER;
        else w_left = w_left - 24'd1;
      end
      w_off = w_off + 9'd1;
    end else begin
      if (w_off == 0) begin
        w_all_zero   = 1'b1;
        w_magic_ok   = 1'b1;
        w_type       = '0;
        w_size       = '0;
        w_stage      = SZ_SKIP;
        w_name_empty = (b == 8'h00);
      end
      if (b != 8'h00) w_all_zero = 1'b0;
      // Octal size: skip leading blanks, take digits, stop at anything else.
      if (w_off >= OFS_SIZE && w_off < OFS_SIZE + SIZE_LEN) begin
        if (!(w_stage == SZ_SKIP && ws)) begin
          if (w_stage != SZ_DONE && dig) begin
            acc8    = ({3'b000, w_size} << 3) + 36'(b[2:0]);
            w_size  = (acc8[35:33] != 0) ? '1 : acc8[32:0];
            w_stage = SZ_DIGITS;
          end else begin
            w_stage = SZ_DONE;
          end
        end
      end
      if (w_off == OFS_TYPE) w_type = b;
      if (w_off >= OFS_MAGIC && w_off < OFS_MAGIC + MAGIC_LEN) begin
        k = int'(w_off) - OFS_MAGIC;
        if (b != USTAR_MAGIC[8*(MAGIC_LEN-1-k) +: 8]) w_magic_ok = 1'b0;
      end
      w_off = w_off + 9'd1;
      // The last header byte decides between an entry and a terminal event.
      if (last) begin
        fire = 1'b1;
        if (w_name_empty) begin
          if (!w_all_zero) begin
            ev.event_res = EV_BAD_HDR;
          end else begin
            w_zeros      = w_zeros + 2'd1;
            fire         = (w_zeros == 2'd2);
            ev.event_res = EV_TWO_ZERO;
          end
        end else if (w_zeros != 0) begin
          ev.event_res    = EV_LONE_ZERO;
          ev.block_number = w_blocks + 32'd1;
        end else if (!w_magic_ok) begin
          ev.event_res = EV_NOT_TAR;
        end else if (w_type != FLAG_REGULAR && w_type != 8'h00) begin
          ev.event_res = EV_BAD_TYPE;
          ev.type_flag = w_type;
        end else begin
          ev.event_res    = EV_ENTRY;
          ev.file_size    = w_size;
          ev.block_number = w_blocks;
          ev.type_flag    = w_type;
          w_blocks        = w_blocks + 32'd1;
          rounded         = {1'b0, w_size} + 34'd511;
          nblk            = rounded[33:9];
          if (nblk != 0) begin
            w_left  = 24'(nblk - 25'd1);
            w_phase = PH_CONTENT;
          end
        end
        if (fire && ev.event_res != EV_ENTRY) w_phase = PH_DONE;
      end
    end
    if (fire) want_events.push_back(ev);
  endtask

  // Stimulus building blocks.
  task automatic push_item(input logic [7:0] b, input logic eos);
    pend_t p;
    p.item.data_byte  = b;
    p.item.stream_end = eos;
    p.drain_first     = drain_next;
    drain_next        = 1'b0;
    archive_bytes.push_back(p);
  endtask

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 5))
      0: return 8'h20;
      1: return 8'h09;
      2: return 8'h0A;
      3: return 8'h0B;
      4: return 8'h0C;
      default: return 8'h0D;
    endcase
  endfunction

  // Spell a size value into the 12-byte field, with blanks, leading zeros and a stop byte.
  function automatic logic [95:0] size_field(input int unsigned s, input size_fmt_t fmt);
    logic [95:0] f;
    logic [7:0]  term;
    int          nd;
    int          room;
    int          nws;
    int          lz;
    int          pos;
    int          k;
    int unsigned t;
    for (k = 0; k < SIZE_LEN; k++) f[8*k +: 8] = 8'($urandom);
    if (fmt == FMT_ANY) fmt = (s != 0) ? FMT_PLAIN : size_fmt_t'($urandom_range(0, 3));
    nd = 1;
    t  = s >> 3;
    while (t != 0) begin
      nd++;
      t = t >> 3;
    end
    pos = 0;
    case (fmt)
      FMT_EMPTY: f = '0;
      FMT_BLANK: for (k = 0; k < SIZE_LEN; k++) f[8*k +: 8] = blank_char();
      FMT_SIGNED: begin
        // A sign stops the parse, so the value reads as zero.
        nws = $urandom_range(0, 3);
        for (k = 0; k < nws; k++) f[8*k +: 8] = blank_char();
        f[8*nws +: 8]     = $urandom_range(0, 1) ? 8'h2B : 8'h2D;
        f[8*(nws+1) +: 8] = 8'h31;
        f[8*(nws+2) +: 8] = 8'h37;
      end
      default: begin
        room = SIZE_LEN - nd;
        nws  = $urandom_range(0, (room > 3) ? 3 : room);
        room = room - nws;
        lz   = $urandom_range(0, (room > 3) ? 3 : room);
        room = room - lz;
        for (k = 0; k < nws; k++) begin
          f[8*pos +: 8] = blank_char();
          pos++;
        end
        for (k = 0; k < lz; k++) begin
          f[8*pos +: 8] = 8'h30;
          pos++;
        end
        for (k = nd - 1; k >= 0; k--) begin
          f[8*pos +: 8] = 8'h30 + 8'((s >> (3 * k)) & 7);
          pos++;
        end
        if (room != 0) begin
          case ($urandom_range(0, 2))
            0: term = 8'h00;
            1: term = blank_char();
            default: begin
              term = 8'($urandom);
              if (term >= 8'h30 && term <= 8'h37) term = 8'h39;
            end
          endcase
          f[8*pos +: 8] = term;
        end
      end
    endcase
    return f;
  endfunction

  task automatic add_header(input logic [7:0] name0, input logic [95:0] szf,
                            input logic [7:0] tflag, input logic [47:0] magic);
    logic [7:0] b;
    int         i;
    for (i = 0; i < BLK; i++) begin
      b = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
      if (i == 0) b = name0;
      else if (i >= OFS_SIZE && i < OFS_SIZE + SIZE_LEN) b = szf[8*(i-OFS_SIZE) +: 8];
      else if (i == OFS_TYPE) b = tflag;
      else if (i >= OFS_MAGIC && i < OFS_MAGIC + MAGIC_LEN)
        b = magic[8*(OFS_MAGIC+MAGIC_LEN-1-i) +: 8];
      push_item(b, 1'b0);
    end
  endtask

  // A well-formed entry: header plus its rounded-up content blocks.
  task automatic add_entry(input int unsigned s, input size_fmt_t fmt);
    add_header(8'($urandom_range(1, 255)), size_field(s, fmt),
               $urandom_range(0, 1) ? FLAG_REGULAR : 8'h00, USTAR_MAGIC);
    repeat (((s + BLK - 1) / BLK) * BLK) push_item(8'($urandom), 1'b0);
  endtask

  task automatic add_zero_block();
    repeat (BLK) push_item(8'h00, 1'b0);
  endtask

  // Input driver: a new transfer is offered once the previous one has gone through.
  always @(negedge clk) begin
    if (rst_n && (in_acc || !in_valid)) begin
      if (tx_gap == 0 && n_acc < quiet_at && $urandom_range(0, 11) == 0)
        tx_gap = $urandom_range(1, 8);
      if (tx_gap != 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (archive_bytes.size() == 0 ||
                   (archive_bytes[0].drain_first && want_events.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        next_byte = archive_bytes.pop_front();
        in_data  <= next_byte.item;
        in_valid <= 1'b1;
      end
    end
  end

  // Result receiver: random stall bursts, plus one long hold-off.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
    end else if (!rst_n || n_acc >= quiet_at) begin
      out_stall <= 1'b0;
    end else begin
      if (rx_gap == 0 && $urandom_range(0, 7) == 0) rx_gap = $urandom_range(1, 8);
      if (rx_gap != 0) begin
        rx_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Long hold-off counter, armed when the zero-size burst starts going in.
  always @(posedge clk) begin
    if (rst_n && !hold_done && n_acc >= hold_at) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: predict on each input transfer, check each result transfer.
  always @(posedge clk) begin
    in_acc <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (want_events.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected event %0d size %0d block %0d flag %h", out_data.event_res,
                     out_data.file_size, out_data.block_number, out_data.type_flag);
        end else begin
          want = want_events.pop_front();
          if (out_data.event_res !== want.event_res || out_data.file_size !== want.file_size ||
              out_data.block_number !== want.block_number ||
              out_data.type_flag !== want.type_flag) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("event mismatch: expected %0d/%0d/%0d/%h got %0d/%0d/%0d/%h",
                       want.event_res, want.file_size, want.block_number, want.type_flag,
                       out_data.event_res, out_data.file_size, out_data.block_number,
                       out_data.type_flag);
          end
        end
      end
      if (in_valid && !in_stall) begin
        walk_byte(in_data);
        n_acc <= n_acc + 1;
      end
    end
  end

  // Build the archive, run it through and judge the outcome.
  initial begin
    end_kind_t   kind;
    logic [95:0] f;
    logic [47:0] m;
    logic [7:0]  t;
    int          k;

    // Directed entries: every zero-size spelling and block boundary sizes, each with a regular flag chosen at random.
    add_entry(0, FMT_EMPTY);
    add_entry(0, FMT_BLANK);
    add_entry(0, FMT_SIGNED);
    add_entry(0, FMT_PLAIN);
    add_entry(1, FMT_PLAIN);
    add_entry(511, FMT_PLAIN);
    add_entry(512, FMT_PLAIN);
    add_entry(513, FMT_PLAIN);
    add_entry(1024, FMT_PLAIN);

    // Burst of header-only entries while the receiver holds off.
    hold_at = archive_bytes.size();
    repeat (8) add_entry(0, FMT_ANY);

    // Random well-formed entries, mostly small.
    drain_next = 1'b1;
    repeat (48)
      add_entry(($urandom_range(0, 7) == 0) ? $urandom_range(1537, 4096)
                                            : $urandom_range(0, 1536), FMT_ANY);

    // One way of ending the archive, chosen at random.
    drain_next = 1'b1;
    kind = end_kind_t'($urandom_range(0, 8));
    case (kind)
      END_TWO_ZERO: begin
        add_zero_block();
        add_zero_block();
      end
      END_ZERO_THEN_HDR: begin
        add_zero_block();
        add_entry($urandom_range(0, 600), FMT_ANY);
      end
      END_ZERO_THEN_EOS: begin
        add_zero_block();
        push_item(8'($urandom), 1'b1);
      end
      END_CLEAN: push_item(8'($urandom), 1'b1);
      END_MID_HEADER: begin
        push_item(8'($urandom_range(1, 255)), 1'b0);
        repeat ($urandom_range(0, 510)) push_item(8'($urandom), 1'b0);
        push_item(8'($urandom), 1'b1);
      end
      END_MID_CONTENT: begin
        // Huge size, saturating or not; the stream stops inside the content.
        if ($urandom_range(0, 1)) begin
          f = {SIZE_LEN{8'h37}};
        end else begin
          f[7:0] = 8'h20;
          for (k = 1; k < SIZE_LEN; k++) f[8*k +: 8] = 8'h30 + 8'($urandom_range(0, 7));
        end
        add_header(8'($urandom_range(1, 255)), f, FLAG_REGULAR, USTAR_MAGIC);
        repeat ($urandom_range(1, 700)) push_item(8'($urandom), 1'b0);
        push_item(8'($urandom), 1'b1);
      end
      END_EMPTY_NAME:
        add_header(8'h00, size_field($urandom_range(0, 100), FMT_ANY), FLAG_REGULAR,
                   USTAR_MAGIC);
      END_BAD_MAGIC: begin
        m = USTAR_MAGIC;
        if ($urandom_range(0, 1)) begin
          m[7:0] = 8'h00;
        end else begin
          k = $urandom_range(0, MAGIC_LEN - 1);
          m[8*k +: 8] = m[8*k +: 8] ^ 8'($urandom_range(1, 255));
        end
        add_header(8'($urandom_range(1, 255)), size_field(0, FMT_ANY), FLAG_REGULAR, m);
      end
      default: begin
        do t = 8'($urandom); while (t == 8'h00 || t == FLAG_REGULAR);
        add_header(8'($urandom_range(1, 255)), size_field(0, FMT_ANY), t, USTAR_MAGIC);
      end
    endcase

    // Trailing noise that a finished walker must drop.
    repeat (16) push_item(8'($urandom), 1'($urandom_range(0, 1)));

    n_items  = archive_bytes.size();
    quiet_at = n_items - n_items / 10;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    wait (n_acc == n_items);
    while (want_events.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_cnt == 0 && want_events.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #30_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* tar_archive_block_walker.f */
rtl/tawb_pkg.sv
rtl/tawb_core.sv
rtl/tawb_outq.sv
rtl/tar_archive_block_walker.sv
rtl/tawb_checker.sv
tb/tb_tar_archive_block_walker.sv
